>>> src/pvra_pkg.sv
package pvra_pkg;

  // Register map indexes
  localparam int REG_CENTER   = 0;
  localparam int REG_FRACTION = 1;
  localparam int REG_WIDTH    = 2;
  localparam int REG_AMP      = 3;
  localparam int REG_BG       = 4;
  localparam int REG_COUNT    = 5;

  localparam int ADDR_W = 5;

  localparam int DEFAULT_MAX_POINTS = 4096;
  localparam int QUEUE_DEPTH        = 2;

  localparam logic [16:0] MU_ONE     = 17'd65536;
  localparam logic [22:0] WIDTH_RST  = 23'd65536;
  localparam logic [16:0] MU_RST     = 17'd32768;
  localparam logic [62:0] SAT63      = {63{1'b1}};
  localparam logic [32:0] SQRT_SAT63 = 33'd3037000499;

  typedef struct packed {
    logic [31:0] radius;
    logic signed [31:0] measured;
    logic        last_sample;
  } in_t;

  typedef struct packed {
    logic [62:0] squared_error_sum;
    logic [62:0] model_sum;
    logic [12:0] sample_count;
  } out_t;

  typedef struct packed {
    logic [31:0] peak_center;
    logic [16:0] lorentz_fraction;
    logic [22:0] peak_width;
    logic [30:0] peak_amplitude;
    logic [30:0] background_level;
  } cfg_t;

  // Queue entry: distance from center, measured intensity, last mark
  typedef struct packed {
    logic [31:0] delta;
    logic signed [31:0] measured;
    logic        last;
  } work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> src/pseudo_voigt_residual_accumulator_unit.sv
// Channel  Direction  Signals                         Payload
// in       input      in_valid / in_stall / in_data    radius, measured, last_sample
// out      output     out_valid / out_stall / out_data squared_error_sum, model_sum, sample_count
// cfg      input      APB psel/penable/pwrite/paddr    five peak registers
//
// In the back end, each sample runs the shared 48-step restoring divider
// twice and then the 16 squarings of the Gaussian term.
// A two-beat queue lets the front take samples while the back end works.
// Reset is synchronous; it clears the sums, the count and the queue and returns the registers to their reset values.
// A finished result waits in the output register; the back end holds only if a
// second result is ready before the first is taken.
module pseudo_voigt_residual_accumulator_unit #(
  parameter int MAX_POINTS = pvra_pkg::DEFAULT_MAX_POINTS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  pvra_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output pvra_pkg::out_t                out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pvra_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  pvra_pkg::cfg_t    cfg;
  pvra_pkg::q_stat_t qstat;
  pvra_pkg::work_t   wentry;
  pvra_pkg::work_t   rentry;
  logic              push;
  logic              pop;
  logic [2:0]        reg_idx;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.peak_center      <= '0;
      cfg.lorentz_fraction <= pvra_pkg::MU_RST;
      cfg.peak_width       <= pvra_pkg::WIDTH_RST;
      cfg.peak_amplitude   <= '0;
      cfg.background_level <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        3'(pvra_pkg::REG_CENTER):   cfg.peak_center      <= pwdata;
        3'(pvra_pkg::REG_FRACTION): cfg.lorentz_fraction <= pwdata[16:0];
        3'(pvra_pkg::REG_WIDTH):    cfg.peak_width       <= pwdata[22:0];
        3'(pvra_pkg::REG_AMP):      cfg.peak_amplitude   <= pwdata[30:0];
        3'(pvra_pkg::REG_BG):       cfg.background_level <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx)
      3'(pvra_pkg::REG_CENTER):   prdata = cfg.peak_center;
      3'(pvra_pkg::REG_FRACTION): prdata = {15'b0, cfg.lorentz_fraction};
      3'(pvra_pkg::REG_WIDTH):    prdata = {9'b0, cfg.peak_width};
      3'(pvra_pkg::REG_AMP):      prdata = {1'b0, cfg.peak_amplitude};
      3'(pvra_pkg::REG_BG):       prdata = {1'b0, cfg.background_level};
      default:                    prdata = '0;
    endcase
  end

  pvra_front u_front (
    .valid (in_valid),
    .data  (in_data),
    .cfg   (cfg),
    .qstat (qstat),
    .stall (in_stall),
    .push  (push),
    .entry (wentry)
  );

  pvra_queue #(
    .DEPTH (pvra_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (wentry),
    .pop   (pop),
    .rdata (rentry),
    .stat  (qstat)
  );

  pvra_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .qstat     (qstat),
    .entry     (rentry),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Never pop an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty) else $error("pop from empty queue");

  // Never push into a full queue
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full) else $error("push into full queue");

  // A pushed beat leaves the queue nonempty next cycle unless it was popped
  a_push_seen: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> !qstat.empty) else $error("pushed beat lost");

endmodule

>>> src/pvra_front.sv
module pvra_front (
  input  logic             valid,
  input  pvra_pkg::in_t    data,
  input  pvra_pkg::cfg_t   cfg,
  input  pvra_pkg::q_stat_t qstat,
  output logic             stall,
  output logic             push,
  output pvra_pkg::work_t  entry
);

  // Accept a beat whenever the queue has room
  assign stall = qstat.full;
  assign push  = valid && !qstat.full;

  // Fold the radius into a distance from the peak center
  always_comb begin
    if (data.radius >= cfg.peak_center) begin
      entry.delta = data.radius - cfg.peak_center;
    end else begin
      entry.delta = cfg.peak_center - data.radius;
    end
    entry.measured = data.measured;
    entry.last     = data.last_sample;
  end

endmodule

>>> src/pvra_queue.sv
module pvra_queue #(
  parameter int DEPTH = pvra_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  pvra_pkg::work_t   wdata,
  input  logic              pop,
  output pvra_pkg::work_t   rdata,
  output pvra_pkg::q_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pvra_pkg::work_t mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;

  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);
  assign rdata      = mem[rptr];

  // Store beats
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> src/pvra_back.sv
module pvra_back #(
  parameter int MAX_POINTS = pvra_pkg::DEFAULT_MAX_POINTS
) (
  input  logic              clk,
  input  logic              rst,
  input  pvra_pkg::cfg_t    cfg,
  input  pvra_pkg::q_stat_t qstat,
  input  pvra_pkg::work_t   entry,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output pvra_pkg::out_t    out_data
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DIV  = 4'd1;
  localparam logic [3:0] ST_USQ  = 4'd2;
  localparam logic [3:0] ST_GSQ  = 4'd3;
  localparam logic [3:0] ST_MIX  = 4'd4;
  localparam logic [3:0] ST_MDL  = 4'd5;
  localparam logic [3:0] ST_ERR  = 4'd6;
  localparam logic [3:0] ST_SQ   = 4'd7;
  localparam logic [3:0] ST_ACC  = 4'd8;

  logic [3:0]  state;
  logic [5:0]  step;
  logic        phase;
  logic [47:0] dvd;
  logic [32:0] dvs;
  logic [32:0] rem;
  logic [23:0] r;
  logic        t_zero;
  logic [31:0] a;
  logic [16:0] lor;
  logic [32:0] shape;
  logic [30:0] model;
  logic [32:0] mag;
  logic [62:0] sq;
  logic signed [31:0] measured;
  logic        last;
  logic [62:0] err_acc;
  logic [62:0] mdl_acc;
  logic [CNT_W-1:0] count;

  logic [33:0] trial;
  logic        qbit;
  logic [22:0] sigma;
  logic [16:0] mu;
  logic [16:0] gau;
  logic [47:0] r_sq;
  logic [63:0] a_sq;
  logic [63:0] amp_prod;
  logic signed [34:0] err;
  logic [63:0] mag_sq;
  logic [63:0] err_sum;
  logic [63:0] mdl_sum;
  logic [62:0] err_acc_next;
  logic [62:0] mdl_acc_next;
  logic [CNT_W-1:0] count_next;
  logic        out_free;
  logic        emit;

  // Effective parameters
  assign sigma = (cfg.peak_width == '0) ? 23'd1 : cfg.peak_width;
  assign mu    = (cfg.lorentz_fraction > pvra_pkg::MU_ONE) ?
                 pvra_pkg::MU_ONE : cfg.lorentz_fraction;

  // Restoring divider step
  assign trial = {rem, dvd[47]};
  assign qbit  = (trial >= {1'b0, dvs});

  assign r_sq     = r * r;
  assign a_sq     = a * a;
  assign gau      = t_zero ? pvra_pkg::MU_ONE : {1'b0, a[31:16]};
  assign amp_prod = {33'b0, cfg.peak_amplitude} * {31'b0, shape};
  assign err      = $signed({4'b0, cfg.background_level}) + $signed({4'b0, model})
                    - 35'(measured);
  assign mag_sq   = {32'b0, mag[31:0]} * {32'b0, mag[31:0]};

  // Saturating accumulation
  assign err_sum      = {1'b0, err_acc} + {1'b0, sq};
  assign mdl_sum      = {1'b0, mdl_acc} + {33'b0, model};
  assign err_acc_next = err_sum[63] ? pvra_pkg::SAT63 : err_sum[62:0];
  assign mdl_acc_next = mdl_sum[63] ? pvra_pkg::SAT63 : mdl_sum[62:0];
  assign count_next   = (count < CNT_W'(MAX_POINTS)) ? count + 1'b1 : count;

  assign out_free = !out_valid || !out_stall;
  assign emit     = (state == ST_ACC) && last && out_free;
  assign pop      = (state == ST_IDLE) && !qstat.empty;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      err_acc   <= '0;
      mdl_acc   <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // Raise the result beat on emit, drop it once taken
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!qstat.empty) begin
            measured <= entry.measured;
            last     <= entry.last;
            dvd      <= {entry.delta, 16'b0};
            dvs      <= {10'b0, sigma};
            rem      <= '0;
            step     <= 6'd47;
            phase    <= 1'b0;
            state    <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem  <= qbit ? 33'(trial - {1'b0, dvs}) : trial[32:0];
          dvd  <= {dvd[46:0], qbit};
          if (step != '0) begin
            step <= step - 1'b1;
          end else if (!phase) begin
            r <= (dvd[46:23] != '0) ? 24'hFFFFFF : {dvd[22:0], qbit};
            state <= ST_USQ;
          end else begin
            lor   <= {dvd[15:0], qbit};
            step  <= 6'd15;
            state <= ST_GSQ;
          end
        end
        ST_USQ: begin
          t_zero <= (r_sq[47:17] == '0);
          a      <= 32'(33'h1_0000_0000 - {2'b0, r_sq[47:17]});
          dvd    <= 48'h1_0000_0000;
          dvs    <= {1'b0, r_sq[47:16]} + 33'd65536;
          rem    <= '0;
          step   <= 6'd47;
          phase  <= 1'b1;
          state  <= ST_DIV;
        end
        ST_GSQ: begin
          a    <= a_sq[63:32];
          step <= step - 1'b1;
          if (step == '0) begin
            state <= ST_MIX;
          end
        end
        ST_MIX: begin
          shape <= ({16'b0, mu} * {16'b0, lor}) +
                   ({16'b0, pvra_pkg::MU_ONE - mu} * {16'b0, gau});
          state <= ST_MDL;
        end
        ST_MDL: begin
          model <= amp_prod[62:32];
          state <= ST_ERR;
        end
        ST_ERR: begin
          mag     <= err[34] ? 33'(-err) : err[32:0];
          state   <= ST_SQ;
        end
        ST_SQ: begin
          sq    <= (mag > pvra_pkg::SQRT_SAT63) ? pvra_pkg::SAT63 : mag_sq[62:0];
          state <= ST_ACC;
        end
        ST_ACC: begin
          if (!last) begin
            err_acc <= err_acc_next;
            mdl_acc <= mdl_acc_next;
            count   <= count_next;
            state   <= ST_IDLE;
          end else if (out_free) begin
            out_data.squared_error_sum <= err_acc_next;
            out_data.model_sum         <= mdl_acc_next;
            out_data.sample_count      <= 13'(count_next);
            err_acc <= '0;
            mdl_acc <= '0;
            count   <= '0;
            state   <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int SAMPLE_LATENCY = 300;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS   = 1050;
  localparam int LONG_ITEMS     = 40;

  logic           clk;
  logic           rst;
  logic           in_valid;
  logic           in_stall;
  pvra_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_stall;
  pvra_pkg::out_t out_data;
  logic           psel;
  logic           penable;
  logic           pwrite;
  logic [pvra_pkg::ADDR_W-1:0] paddr;
  logic [31:0]    pwdata;
  logic [31:0]    prdata;
  logic           pready;

  int send_idle_pct;
  int recv_idle_pct;
  int idle_cycles;
  int profiles_sent;
  int beats_sent;

  pseudo_voigt_residual_accumulator_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predicts profile sums and checks them against the result beats
  class residual_scoreboard;
    logic [31:0] center;
    logic [16:0] fraction;
    logic [22:0] width;
    logic [30:0] amplitude;
    logic [30:0] background;
    logic [62:0] err_acc;
    logic [62:0] model_acc;
    int unsigned count;
    pvra_pkg::out_t pending_sums[$];
    int mismatches;
    int results_seen;

    function new();
      center = 0;
      fraction = pvra_pkg::MU_RST;
      width = pvra_pkg::WIDTH_RST;
      amplitude = 0;
      background = 0;
      err_acc = 0;
      model_acc = 0;
      count = 0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function void write_reg(int idx, logic [31:0] val);
      case (idx)
        pvra_pkg::REG_CENTER:   center = val;
        pvra_pkg::REG_FRACTION: fraction = val[16:0];
        pvra_pkg::REG_WIDTH:    width = val[22:0];
        pvra_pkg::REG_AMP:      amplitude = val[30:0];
        pvra_pkg::REG_BG:       background = val[30:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] gauss_term(logic [63:0] t);
      logic [63:0] a;
      logic [127:0] p;
      if (t == 0) return 64'd65536;
      if (t >= 64'h1_0000_0000) return 0;
      a = 64'h1_0000_0000 - t;
      for (int i = 0; i < 16; i++) begin
        p = a * a;
        a = 64'(p >> 32);
      end
      return a >> 16;
    endfunction

    function logic [62:0] sat_add(logic [62:0] a, logic [63:0] b);
      logic [64:0] s;
      s = a + b;
      return (s > pvra_pkg::SAT63) ? pvra_pkg::SAT63 : s[62:0];
    endfunction

    function void note_sample(pvra_pkg::in_t s);
      logic [63:0] sigma, mu, d, r, u, lor, gau, shape, model, calc, mag, sq;
      logic [127:0] prod;
      longint signed err;
      pvra_pkg::out_t res;
      sigma = (width == 0) ? 64'd1 : 64'(width);
      mu = (fraction > pvra_pkg::MU_ONE) ? 64'd65536 : 64'(fraction);
      d = (s.radius >= center) ? 64'(s.radius - center) : 64'(center - s.radius);
      r = (d << 16) / sigma;
      if (r > 64'hFF_FFFF) r = 64'hFF_FFFF;
      u = (r * r) >> 16;
      lor = 64'h1_0000_0000 / (u + 64'd65536);
      gau = gauss_term(u >> 1);
      shape = mu * lor + (64'd65536 - mu) * gau;
      prod = 128'(amplitude) * 128'(shape);
      model = 64'(prod >> 32);
      calc = 64'(background) + model;
      err = longint'(calc) - longint'(s.measured);
      mag = (err < 0) ? 64'(-err) : 64'(err);
      sq = (mag > 64'(pvra_pkg::SQRT_SAT63)) ? 64'(pvra_pkg::SAT63) : mag * mag;
      err_acc = sat_add(err_acc, sq);
      model_acc = sat_add(model_acc, model);
      if (count < pvra_pkg::DEFAULT_MAX_POINTS) count++;
      if (s.last_sample) begin
        res.squared_error_sum = err_acc;
        res.model_sum = model_acc;
        res.sample_count = count[12:0];
        pending_sums.push_back(res);
        err_acc = 0;
        model_acc = 0;
        count = 0;
      end
    endfunction

    function void check_result(pvra_pkg::out_t got);
      pvra_pkg::out_t want;
      results_seen++;
      if (pending_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
        return;
      end
      want = pending_sums.pop_front();
      if (got.squared_error_sum !== want.squared_error_sum ||
          got.model_sum !== want.model_sum ||
          got.sample_count !== want.sample_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: err exp %0d got %0d, model exp %0d got %0d, cnt exp %0d got %0d",
                   want.squared_error_sum, got.squared_error_sum,
                   want.model_sum, got.model_sum, want.sample_count, got.sample_count);
      end
    endfunction
  endclass

  residual_scoreboard sums_board;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Watchdog: count cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: check accepted results, stall at random
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sums_board.check_result(out_data);
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // A setup phase and an access phase, then an idle phase on the bus
  task automatic apb_write(int idx, logic [31:0] val);
    in_valid <= 0;
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= pvra_pkg::ADDR_W'(4 * idx); pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    sums_board.write_reg(idx, val);
    @(posedge clk);
  endtask

  // Drop valid, wait for every expected result, then let the back end drain
  task automatic drain();
    in_valid <= 0;
    while (sums_board.pending_sums.size() != 0) @(posedge clk);
    repeat (SAMPLE_LATENCY) @(posedge clk);
  endtask

  // Hold valid high after the beat; the next idle cycle, an APB write or drain drops it
  task automatic send_sample(logic [31:0] radius, logic [31:0] meas, logic last);
    pvra_pkg::in_t s;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    s.radius = radius;
    s.measured = meas;
    s.last_sample = last;
    in_valid <= 1;
    in_data <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sums_board.note_sample(s);
    beats_sent++;
    if (last) profiles_sent++;
  endtask

  task automatic set_peak(logic [31:0] c, logic [31:0] f, logic [31:0] w,
                          logic [31:0] a, logic [31:0] b);
    apb_write(pvra_pkg::REG_CENTER, c);
    apb_write(pvra_pkg::REG_FRACTION, f);
    apb_write(pvra_pkg::REG_WIDTH, w);
    apb_write(pvra_pkg::REG_AMP, a);
    apb_write(pvra_pkg::REG_BG, b);
  endtask

  // Random profile: radii mostly around the center, measured mostly near the background level
  task automatic random_profile(int len);
    logic [31:0] rad, meas;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(3))
        0: rad = $urandom;
        default: rad = sums_board.center + $urandom_range(32'h40000) - 32'h20000;
      endcase
      case ($urandom_range(3))
        0: meas = $urandom;
        default: meas = sums_board.background + $urandom_range(4096) - 2048;
      endcase
      send_sample(rad, meas, i == len - 1);
    end
  endtask

  initial begin
    int left;
    sums_board = new();
    rst = 1;
    in_valid = 0; in_data = '0; out_stall = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    send_idle_pct = 0; recv_idle_pct = 0;
    idle_cycles = 0; profiles_sent = 0; beats_sent = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: reset settings, then extremes and special cases
    send_sample(32'h0, 32'h0, 1);
    send_sample(32'hFFFF_FFFF, 32'h8000_0000, 0);
    send_sample(32'h0, 32'h7FFF_FFFF, 1);
    drain();
    set_peak(32'h0010_0000, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_sample(32'h0010_0000, 32'h8000_0000, 0);
    send_sample(32'h0010_0001, 32'h7FFF_FFFF, 0);
    send_sample(32'hFFFF_FFFF, 32'h0, 1);
    drain();
    set_peak(32'hFFFF_FFFF, 32'h1_FFFF, 32'd6553600, 32'd25600, 32'd0);
    send_sample(32'hFFFF_FFFF, 32'd25600, 1);
    send_sample(32'h0, 32'h0, 1);
    drain();
    set_peak(32'h0008_0000, 32'd65536, 32'd3277, 32'd100000, 32'd500);
    send_sample(32'h0008_0000, 32'd100500, 0);
    send_sample(32'h0008_1000, 32'd0, 0);
    send_sample(32'h0009_0000, 32'hFFFF_FF00, 1);
    drain();
    apb_write(7, 32'hDEAD_BEEF);
    send_sample(32'h0008_0100, 32'd200, 1);
    drain();

    // Longer profile under one peak setting with random samples
    set_peak(32'h0100_0000, 32'd40000, 32'd65536, 32'd1000, 32'd10);
    for (int i = 0; i < LONG_ITEMS; i++)
      send_sample($urandom, $urandom, i == LONG_ITEMS - 1);
    drain();

    // Random phases with changing idle patterns and peak settings
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 45 : 0;
      recv_idle_pct = (ph == 0) ? 45 : (ph == 1) ? 38 : 0;
      left = RANDOM_ITEMS / 3;
      while (left > 0) begin
        int len;
        drain();
        set_peak($urandom, $urandom_range(70000), $urandom_range(6553600, 3277),
                 ($urandom_range(3) == 0) ? $urandom_range(32'h7FFF_FFFF)
                                          : $urandom_range(1 << 20),
                 ($urandom_range(3) == 0) ? $urandom_range(32'h7FFF_FFFF)
                                          : $urandom_range(1 << 16));
        len = $urandom_range(20, 1);
        random_profile(len);
        left -= len;
      end
    end

    drain();
    $display("covered %0d samples in %0d profiles, %0d results checked",
             beats_sent, profiles_sent, sums_board.results_seen);
    $display("mismatches: %0d", sums_board.mismatches);
    if (sums_board.mismatches == 0 && sums_board.pending_sums.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

>>> sim.f
src/pvra_pkg.sv
src/pvra_front.sv
src/pvra_queue.sv
src/pvra_back.sv
src/pseudo_voigt_residual_accumulator_unit.sv
sim/testbench.sv
